@@ hw/rtl/wsbw_pkg.sv @@
// shared types and constants of the wind sway blend weight block
`default_nettype none

package wsbw_pkg;

    // key shapes
    localparam int MAX_KEYS = 16;
    localparam int KEY_W    = 4;
    localparam int CNT_W    = 5;

    // wind and magnitude widths
    localparam int WIND_W = 16;
    localparam int MAG_W  = 16;
    localparam int SUM_W  = 32;

    // q16 fractions
    localparam int Q_W = 17;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [Q_W:0]   TWO_Q16 = 18'h20000;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRENGTH_LOW  = 3'd0,
        CFG_STRENGTH_HIGH = 3'd1,
        CFG_STEP_SLOW     = 3'd2,
        CFG_STEP_FAST     = 3'd3,
        CFG_KEY_COUNT     = 3'd4
    } t_cfg_idx;

    // register values after reset
    localparam logic [15:0]      RST_STRENGTH_LOW  = 16'd50;
    localparam logic [15:0]      RST_STRENGTH_HIGH = 16'd250;
    localparam logic [15:0]      RST_STEP_SLOW     = 16'd21845;
    localparam logic [15:0]      RST_STEP_FAST     = 16'd43690;
    localparam logic [CNT_W-1:0] RST_KEY_COUNT     = 5'd2;

    typedef struct packed {
        logic [15:0]      strength_low;
        logic [15:0]      strength_high;
        logic [15:0]      step_slow;
        logic [15:0]      step_fast;
        logic [CNT_W-1:0] key_count;
    } t_cfg;

    typedef logic [SUM_W-1:0] t_sum;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // magnitude of a two's complement component, -32768 maps to 32768
    function automatic logic [MAG_W-1:0] abs16(input logic signed [WIND_W-1:0] v);
        logic [MAG_W-1:0] u;
        u = v;
        return v[WIND_W-1] ? MAG_W'(~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wind_sway_blend_weights_core.sv @@
// top level of the wind sway blend weight block: config registers, front, queue and back
// the back part works on one request at a time through a 16 step square root and,
// when the strength lies between the thresholds, a 17 step width divider; the front
// can take further requests meanwhile until the queue is full
// reset: synchronous active low, restores register defaults, clears phase and key
`default_nettype none

module wind_sway_blend_weights_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wsbw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wsbw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [15:0]                  i_wind_x,
    input  logic signed [15:0]                  i_wind_y,
    input  logic signed [15:0]                  i_wind_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [3:0]                          o_first_key,
    output logic [16:0]                         o_first_weight,
    output logic [3:0]                          o_second_key,
    output logic [16:0]                         o_second_weight,
    output logic [16:0]                         o_rest_weight,
    output logic [16:0]                         o_sway_width
);
    import wsbw_pkg::*;

    t_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strength_low  <= RST_STRENGTH_LOW;
            r_cfg.strength_high <= RST_STRENGTH_HIGH;
            r_cfg.step_slow     <= RST_STEP_SLOW;
            r_cfg.step_fast     <= RST_STEP_FAST;
            r_cfg.key_count     <= RST_KEY_COUNT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STRENGTH_LOW:  r_cfg.strength_low  <= i_cfg_data;
                CFG_STRENGTH_HIGH: r_cfg.strength_high <= i_cfg_data;
                CFG_STEP_SLOW:     r_cfg.step_slow     <= i_cfg_data;
                CFG_STEP_FAST:     r_cfg.step_fast     <= i_cfg_data;
                CFG_KEY_COUNT:     r_cfg.key_count     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic push;
    t_sum push_data;
    logic full;
    logic pop;
    t_sum pop_data;
    logic empty;

    // front: magnitude squared
    wsbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_wind_x    (i_wind_x),
        .i_wind_y    (i_wind_y),
        .i_wind_z    (i_wind_z),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // queue
    wsbw_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    // back: root, width, phase, weights
    wsbw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (empty),
        .o_pop           (pop),
        .i_pop_data      (pop_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_first_key     (o_first_key),
        .o_first_weight  (o_first_weight),
        .o_second_key    (o_second_key),
        .o_second_weight (o_second_weight),
        .o_rest_weight   (o_rest_weight),
        .o_sway_width    (o_sway_width)
    );

endmodule

`default_nettype wire

@@ hw/rtl/wsbw_front.sv @@
// front part: takes wind requests and builds the squared magnitude
`default_nettype none

module wsbw_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [15:0]          i_wind_x,
    input  logic signed [15:0]          i_wind_y,
    input  logic signed [15:0]          i_wind_z,
    output logic                        o_push,
    output wsbw_pkg::t_sum              o_push_data,
    input  logic                        i_full
);
    import wsbw_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAC,
        F_PUSH
    } t_fstate;

    t_fstate          r_state;
    logic [MAG_W-1:0] r_mag [3];
    logic [1:0]       r_cnt;
    t_sum             r_acc;

    logic [SUM_W-1:0] sq;
    t_sum             n_acc;

    // one square per cycle, accumulated
    assign sq    = SUM_W'(r_mag[r_cnt]) * SUM_W'(r_mag[r_cnt]);
    assign n_acc = r_acc + sq;

    // no request is taken while in reset
    assign o_in_stall  = (r_state != F_IDLE) || !i_rst_n;
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_push_data = r_acc;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_mag[0] <= abs16(i_wind_x);
                        r_mag[1] <= abs16(i_wind_y);
                        r_mag[2] <= abs16(i_wind_z);
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        r_state  <= F_MAC;
                    end
                end
                F_MAC: begin
                    r_acc <= n_acc;
                    if (r_cnt == 2'd2) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/wsbw_fifo.sv @@
// short queue of squared magnitudes between front and back
`default_nettype none

module wsbw_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsbw_pkg::t_sum i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output wsbw_pkg::t_sum o_pop_data,
    output logic           o_empty
);
    import wsbw_pkg::*;

    t_sum                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full     = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/wsbw_back.sv @@
// back part: square root, width divide, phase accumulator and blend weights
`default_nettype none

module wsbw_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wsbw_pkg::t_cfg              i_cfg,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  wsbw_pkg::t_sum              i_pop_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [3:0]                  o_first_key,
    output logic [16:0]                 o_first_weight,
    output logic [3:0]                  o_second_key,
    output logic [16:0]                 o_second_weight,
    output logic [16:0]                 o_rest_weight,
    output logic [16:0]                 o_sway_width
);
    import wsbw_pkg::*;

    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQRT,
        B_CLASS,
        B_DIV,
        B_SPEED,
        B_PHASE,
        B_TRI,
        B_WEIGHT,
        B_DONE
    } t_bstate;

    t_bstate            r_state;
    t_sum               r_n;
    logic [MAG_W:0]     r_rem;
    logic [MAG_W-1:0]   r_root;
    logic [STEP_W-1:0]  r_step;
    logic [MAG_W:0]     r_drem;
    logic [MAG_W-1:0]   r_div;
    logic [Q_W-1:0]     r_width;
    logic               r_up;
    logic [Q_W+15:0]    r_prod;
    logic [Q_W-1:0]     r_phase;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_next;
    logic [Q_W-1:0]     r_tri;
    logic [2*Q_W-1:0]   r_wprod;

    logic               r_out_valid;
    logic [KEY_W-1:0]   r_first_key;
    logic [Q_W-1:0]     r_first_weight;
    logic [KEY_W-1:0]   r_second_key;
    logic [Q_W-1:0]     r_second_weight;
    logic [Q_W-1:0]     r_rest_weight;
    logic [Q_W-1:0]     r_sway_width;

    // effective key count, clamped to one .. MAX_KEYS
    logic [CNT_W-1:0] cnt_eff;
    always_comb begin
        if (i_cfg.key_count == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (i_cfg.key_count > CNT_W'(MAX_KEYS)) begin
            cnt_eff = CNT_W'(MAX_KEYS);
        end else begin
            cnt_eff = i_cfg.key_count;
        end
    end

    // square root step: two radicand bits per cycle
    logic [MAG_W+2:0] sq_shift;
    logic [MAG_W+2:0] sq_trial;
    logic             sq_ge;
    assign sq_shift = {r_rem, r_n[SUM_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    // restoring divide step: one quotient bit per cycle
    logic             dv_ge;
    logic [MAG_W:0]   dv_diff;
    assign dv_ge   = (r_drem >= {1'b0, r_div});
    assign dv_diff = dv_ge ? (r_drem - {1'b0, r_div}) : r_drem;

    // speed interpolation
    logic [15:0] step_diff;
    logic [15:0] speed;
    logic [15:0] delta;
    assign step_diff = r_up ? (i_cfg.step_fast - i_cfg.step_slow)
                            : (i_cfg.step_slow - i_cfg.step_fast);
    assign delta = r_prod[31:16];
    assign speed = r_up ? (i_cfg.step_slow + delta) : (i_cfg.step_slow - delta);

    // phase advance and key wrap
    logic [Q_W:0]     n_phase_sum;
    logic             wrap;
    logic [Q_W-1:0]   n_phase;
    logic [CNT_W-1:0] key_inc;
    logic [KEY_W-1:0] n_key;
    assign n_phase_sum = {1'b0, r_phase} + (Q_W+1)'(speed);
    assign wrap        = (n_phase_sum >= TWO_Q16);
    assign n_phase     = wrap ? Q_W'(n_phase_sum - TWO_Q16) : Q_W'(n_phase_sum);
    assign key_inc     = {1'b0, r_key} + CNT_W'(1);
    always_comb begin
        if (!wrap) begin
            n_key = r_key;
        end else if (key_inc >= cnt_eff) begin
            n_key = '0;
        end else begin
            n_key = key_inc[KEY_W-1:0];
        end
    end

    // triangle wave and weights
    logic [Q_W-1:0] n_tri;
    logic [Q_W-1:0] w1;
    assign n_tri = (r_phase > ONE_Q16) ? Q_W'(TWO_Q16 - {1'b0, r_phase}) : r_phase;
    assign w1    = r_wprod[Q_W+15:16];

    logic [MAG_W-1:0] str;
    assign str = r_root;

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    // sequencer with result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_step      <= '0;
            r_phase     <= '0;
            r_key       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken, and no new one loaded in this cycle
            if (r_out_valid && !i_out_stall && (r_state != B_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_n     <= i_pop_data;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_state <= B_SQRT;
                    end
                end
                B_SQRT: begin
                    r_n <= {r_n[SUM_W-3:0], 2'b00};
                    if (sq_ge) begin
                        r_rem  <= (MAG_W+1)'(sq_shift - sq_trial);
                        r_root <= {r_root[MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= (MAG_W+1)'(sq_shift);
                        r_root <= {r_root[MAG_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                        r_state <= B_CLASS;
                    end
                end
                B_CLASS: begin
                    r_up   <= (i_cfg.step_fast >= i_cfg.step_slow);
                    r_step <= '0;
                    priority if (str < i_cfg.strength_low) begin
                        r_width <= '0;
                        r_state <= B_SPEED;
                    end else if (str > i_cfg.strength_high ||
                                 i_cfg.strength_high <= i_cfg.strength_low) begin
                        r_width <= ONE_Q16;
                        r_state <= B_SPEED;
                    end else begin
                        r_drem  <= {1'b0, str - i_cfg.strength_low};
                        r_div   <= i_cfg.strength_high - i_cfg.strength_low;
                        r_width <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_drem  <= {dv_diff[MAG_W-1:0], 1'b0};
                    r_width <= {r_width[Q_W-2:0], dv_ge};
                    r_step  <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= B_SPEED;
                    end
                end
                B_SPEED: begin
                    r_prod  <= (Q_W+16)'(r_width) * (Q_W+16)'(step_diff);
                    r_state <= B_PHASE;
                end
                B_PHASE: begin
                    r_phase <= n_phase;
                    r_key   <= n_key;
                    r_state <= B_TRI;
                end
                B_TRI: begin
                    r_tri <= n_tri;
                    if (({1'b0, r_key} + CNT_W'(1)) >= cnt_eff) begin
                        r_next <= '0;
                    end else begin
                        r_next <= r_key + 1'b1;
                    end
                    r_state <= B_WEIGHT;
                end
                B_WEIGHT: begin
                    r_wprod <= (2*Q_W)'(r_width) * (2*Q_W)'(r_tri);
                    r_state <= B_DONE;
                end
                B_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid     <= 1'b1;
                        r_first_key     <= r_key;
                        r_first_weight  <= w1;
                        r_second_key    <= r_next;
                        r_second_weight <= r_width - w1;
                        r_rest_weight   <= ONE_Q16 - r_width;
                        r_sway_width    <= r_width;
                        r_state         <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_first_key     = r_first_key;
    assign o_first_weight  = r_first_weight;
    assign o_second_key    = r_second_key;
    assign o_second_weight = r_second_weight;
    assign o_rest_weight   = r_rest_weight;
    assign o_sway_width    = r_sway_width;

    // the two key weights split the sway width
    a_weight_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((18'(o_first_weight) + 18'(o_second_weight)) == 18'(o_sway_width)))
        else $error("key weights do not add up to sway width");

    // rest weight complements the sway width
    a_rest_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((18'(o_sway_width) + 18'(o_rest_weight)) == 18'(ONE_Q16)))
        else $error("rest weight does not complement sway width");

    // second key stays inside the key count
    a_second_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_second_key} < cnt_eff))
        else $error("second key beyond key count");

    // a popped request always starts the root
    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == B_SQRT))
        else $error("pop did not start the square root");

endmodule

`default_nettype wire
